@@ hw/rtl/lbl_pkg.sv @@
// ----------------------------------------------------------------------------
// lbl_pkg
// shared types and constants of the led breathe level generator
// ----------------------------------------------------------------------------
package lbl_pkg;

  localparam int LEVEL_W   = 8;
  localparam int SLOW_W    = 7;
  localparam int NUM_CH    = 4;
  localparam int BIT_CNT_W = $clog2(LEVEL_W);
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = NUM_CH * LEVEL_W;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GREEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLUE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WHITE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_FACTOR = 3'd5;

  // reset values and level constants
  localparam logic [LEVEL_W-1:0] RESET_STEPS = 8'd12;
  localparam logic [SLOW_W-1:0]  RESET_SLOW  = 7'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'hFF;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_HOLD
  } lbl_state_t;

endpackage

@@ hw/rtl/led_breathe_level_generator_unit.sv @@
// ----------------------------------------------------------------------------
// led_breathe_level_generator_unit
// breathing effect levels: four peak levels divided by a sweeping divisor
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid/tready      tdata[0] restart
// m_axis    out        m_axis_tvalid/tready      tdata red, green, blue, white
// cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// the tick transfer edge loads the dividers, then the four bit-serial restoring
// dividers run in ST_DIVIDE (one quotient bit per cycle each), then ST_HOLD
// loads the output register once it is free, and only then, back in ST_IDLE,
// is the next tick taken, so the block takes no tick while it divides
// the output register lets the next tick be taken while a result waits
// a stalled result holds the dividers in their last state until it drains
// rst is synchronous: divisor returns to 12, brightening, control and config registers to reset
// ----------------------------------------------------------------------------
module led_breathe_level_generator_unit (
  input  logic                              clk,
  input  logic                              rst,
  // slave side: frame ticks
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lbl_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [0] restart, rest zero
  // master side: channel levels
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lbl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // red, green, blue, white
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lbl_pkg::LEVEL_W-1:0]       cfg_data
);
  import lbl_pkg::*;

  // configuration registers, peaks kept as one lane per channel
  logic [LEVEL_W-1:0] peak [NUM_CH];
  logic [LEVEL_W-1:0] step_count;
  logic [SLOW_W-1:0]  slow_factor;

  // sweep state
  logic [LEVEL_W-1:0] divisor;
  logic [LEVEL_W-1:0] divisor_next;
  logic               dimming;
  logic               dimming_next;

  lbl_state_t state, state_next;
  logic [BIT_CNT_W-1:0] bit_cnt;

  // serial divider lanes: quotient shifts in where the dividend shifts out
  logic [LEVEL_W-1:0] quo      [NUM_CH];
  logic [LEVEL_W-1:0] rem      [NUM_CH];
  logic [LEVEL_W-1:0] quo_next [NUM_CH];
  logic [LEVEL_W-1:0] rem_next [NUM_CH];
  logic [LEVEL_W-1:0] dvs;

  logic [2*LEVEL_W-2:0] limit_prod;
  logic [LEVEL_W-1:0]   dim_limit;
  logic [LEVEL_W-1:0]   stepped;

  logic in_xfer;
  logic out_free;
  logic load_out;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign load_out      = (state == ST_HOLD) && out_free;

  // a divisor of zero divides as one
  assign dvs = (divisor == '0) ? LEVEL_ONE : divisor;

  always_comb begin
    logic [LEVEL_W:0]   shifted;
    logic [LEVEL_W+1:0] diff;
    for (int i = 0; i < NUM_CH; i++) begin
      shifted     = {rem[i], quo[i][LEVEL_W-1]};
      diff        = {1'b0, shifted} - {2'b00, dvs};
      if (!diff[LEVEL_W+1]) begin
        rem_next[i] = diff[LEVEL_W-1:0];
        quo_next[i] = {quo[i][LEVEL_W-2:0], 1'b1};
      end else begin
        rem_next[i] = shifted[LEVEL_W-1:0];
        quo_next[i] = {quo[i][LEVEL_W-2:0], 1'b0};
      end
    end
  end

  // dimmest divisor, saturated to the level range
  assign limit_prod = (2*LEVEL_W-1)'(step_count) * (2*LEVEL_W-1)'(slow_factor);
  assign dim_limit  = (|limit_prod[2*LEVEL_W-2:LEVEL_W]) ? LEVEL_MAX
                                                         : limit_prod[LEVEL_W-1:0];

  // one sweep step after the frame has been divided
  always_comb begin
    if (!dimming) begin
      stepped      = (divisor > LEVEL_ONE) ? divisor - LEVEL_ONE : divisor;
      dimming_next = (stepped <= LEVEL_ONE);
    end else begin
      stepped      = (divisor < LEVEL_MAX) ? divisor + LEVEL_ONE : divisor;
      dimming_next = !(stepped >= dim_limit);
    end
    divisor_next = stepped;
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (bit_cnt == BIT_CNT_W'(LEVEL_W-1)) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) peak[i] <= '0;
      step_count  <= RESET_STEPS;
      slow_factor <= RESET_SLOW;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_RED:     peak[0]     <= cfg_data;
        REG_MAX_GREEN:   peak[1]     <= cfg_data;
        REG_MAX_BLUE:    peak[2]     <= cfg_data;
        REG_MAX_WHITE:   peak[3]     <= cfg_data;
        REG_STEP_COUNT:  step_count  <= cfg_data;
        REG_SLOW_FACTOR: slow_factor <= cfg_data[SLOW_W-1:0];
        default: ;
      endcase
    end
  end

  // divisor and direction: restart on a transfer with tdata[0] set, step on result load
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= RESET_STEPS;
      dimming <= 1'b0;
    end else if (in_xfer) begin
      if (s_axis_tdata[0]) begin
        divisor <= step_count;
        dimming <= 1'b0;
      end
    end else if (load_out) begin
      divisor <= divisor_next;
      dimming <= dimming_next;
    end
  end

  // bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (in_xfer) begin
      bit_cnt <= '0;
    end else if (state == ST_DIVIDE) begin
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
  end

  // divider lanes, payload only
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < NUM_CH; i++) begin
        quo[i] <= peak[i];
        rem[i] <= '0;
      end
    end else if (state == ST_DIVIDE) begin
      for (int i = 0; i < NUM_CH; i++) begin
        quo[i] <= quo_next[i];
        rem[i] <= rem_next[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {quo[3], quo[2], quo[1], quo[0]};
    end
  end

endmodule

@@ hw/rtl/lbl_checker.sv @@
// ----------------------------------------------------------------------------
// lbl_checker
// port checks of the led breathe level generator
// ----------------------------------------------------------------------------
module lbl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lbl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import lbl_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a tick transfer makes the block busy
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("tick taken while dividing");

  // a new result only appears at the end of a busy spell
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without division");

endmodule

bind led_breathe_level_generator_unit lbl_checker u_lbl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
